@@ rtl/sdf_pkg.sv @@
package sdf_pkg;

  // Field and limit sizes
  localparam int VALUE_BITS  = 32;
  localparam int MAX_CHARS   = 31;
  localparam int MIN_WIDTH_W = 5;
  localparam int CHAR_W      = 8;

  // Decimal digits needed for the largest magnitude, 2**(VALUE_BITS-1)
  localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
  localparam int DIG_W      = $clog2(NUM_DIGITS + 1);
  localparam int PAD_W      = $clog2(MAX_CHARS + 1);
  localparam int CMP_W      = $clog2(MAX_CHARS + NUM_DIGITS + 2);

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  // Converted number handed from the converter to the emitter
  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;   // most significant digit in the top nibble
    logic [DIG_W-1:0] ndig;  // significant digits, 1 or more
  } sdf_num_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_SHIFT,
    CV_TRIM,
    CV_DONE
  } sdf_conv_state_e;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_PAD,
    EM_SIGN,
    EM_DIGIT
  } sdf_emit_state_e;

endpackage

@@ rtl/sdf_conv.sv @@
module sdf_conv import sdf_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         num_valid_o,
  input  logic                         num_take_i,
  output sdf_num_t                     num_o
);

  sdf_conv_state_e state_q, state_d;
  logic [BIT_CNT_W-1:0] cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [BCD_W-1:0] bcd_q, bcd_d, dab;
  logic [DIG_W-1:0] ndig_q, ndig_d;
  logic neg_q, neg_d;
  logic in_acc;

  assign in_acc = in_valid_i && (state_q == CV_IDLE);
  assign in_stall_o = (state_q != CV_IDLE);
  assign num_valid_o = (state_q == CV_DONE);
  assign num_o = '{neg: neg_q, bcd: bcd_q, ndig: ndig_q};

  // Add-3 correction on every BCD digit ahead of the shift
  always_comb begin
    dab = bcd_q;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        dab[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
    end
  end

  // Sequencer: magnitude, one bit per cycle into BCD, then leading-zero trim
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    ndig_d  = ndig_q;
    neg_d   = neg_q;
    case (state_q)
      CV_IDLE: begin
        if (in_acc) begin
          neg_d   = value_i[VALUE_BITS-1];
          mag_d   = value_i[VALUE_BITS-1] ? (~value_i + 1'b1) : value_i;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = CV_SHIFT;
        end
      end
      CV_SHIFT: begin
        {bcd_d, mag_d} = {dab[BCD_W-2:0], mag_q, 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == BIT_CNT_W'(VALUE_BITS - 1)) begin
          ndig_d  = DIG_W'(NUM_DIGITS);
          state_d = CV_TRIM;
        end
      end
      CV_TRIM: begin
        if ((bcd_q[BCD_W-1 -: 4] == 4'd0) && (ndig_q > DIG_W'(1))) begin
          bcd_d  = {bcd_q[BCD_W-5:0], 4'd0};
          ndig_d = ndig_q - 1'b1;
        end else begin
          state_d = CV_DONE;
        end
      end
      CV_DONE: begin
        if (num_take_i) begin
          state_d = CV_IDLE;
        end
      end
      default: state_d = CV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    ndig_q <= ndig_d;
    neg_q  <= neg_d;
  end

endmodule

@@ rtl/sdf_emit.sv @@
module sdf_emit import sdf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [MIN_WIDTH_W-1:0] min_width_i,
  input  logic                   num_valid_i,
  output logic                   num_take_o,
  input  sdf_num_t               num_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [CHAR_W-1:0]      text_char_o,
  output logic                   last_char_o
);

  sdf_emit_state_e state_q, state_d;
  logic [PAD_W-1:0] pad_q, pad_d;
  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic [DIG_W-1:0] ndig_q, ndig_d;
  logic neg_q, neg_d;
  logic out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic last_q, last_d;
  logic adv;
  logic [CMP_W-1:0] len, width;

  assign out_valid_o = out_valid_q;
  assign text_char_o = char_q;
  assign last_char_o = last_q;

  // Output register may be reloaded when empty or being transferred
  assign adv = !out_valid_q || !out_stall_i;
  assign num_take_o = (state_q == EM_IDLE) && num_valid_i;

  // Text length and clamped minimum width
  always_comb begin
    len = CMP_W'(num_i.ndig) + CMP_W'(num_i.neg);
    if (CMP_W'(min_width_i) > CMP_W'(MAX_CHARS)) begin
      width = CMP_W'(MAX_CHARS);
    end else begin
      width = CMP_W'(min_width_i);
    end
  end

  // Blanks, then sign, then digits from the top nibble down
  always_comb begin
    state_d     = state_q;
    pad_d       = pad_q;
    bcd_d       = bcd_q;
    ndig_d      = ndig_q;
    neg_d       = neg_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      EM_IDLE: begin
        if (num_valid_i) begin
          bcd_d  = num_i.bcd;
          ndig_d = num_i.ndig;
          neg_d  = num_i.neg;
          if (width > len) begin
            pad_d   = PAD_W'(width - len);
            state_d = EM_PAD;
          end else begin
            pad_d   = '0;
            state_d = num_i.neg ? EM_SIGN : EM_DIGIT;
          end
        end
      end
      EM_PAD: begin
        if (adv) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_BLANK;
          last_d      = 1'b0;
          pad_d       = pad_q - 1'b1;
          if (pad_q == PAD_W'(1)) begin
            state_d = neg_q ? EM_SIGN : EM_DIGIT;
          end
        end
      end
      EM_SIGN: begin
        if (adv) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_MINUS;
          last_d      = 1'b0;
          state_d     = EM_DIGIT;
        end
      end
      EM_DIGIT: begin
        if (adv) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_ZERO + {4'd0, bcd_q[BCD_W-1 -: 4]};
          last_d      = (ndig_q == DIG_W'(1));
          bcd_d       = {bcd_q[BCD_W-5:0], 4'd0};
          ndig_d      = ndig_q - 1'b1;
          if (ndig_q == DIG_W'(1)) begin
            state_d = EM_IDLE;
          end
        end
      end
      default: state_d = EM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= EM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pad_q  <= pad_d;
    bcd_q  <= bcd_d;
    ndig_q <= ndig_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

endmodule

@@ rtl/signed_decimal_formatter.sv @@
// Signed decimal formatter: one signed integer in, its decimal ASCII text out.
//
// Input channel: value_i with in_valid_i / in_stall_o; a transfer happens on a
// rising edge with valid high and stall low. Output channel: one character per
// transfer on text_char_o, with last_char_o high on the final character of a
// value. Text is leading blanks (up to min_width), then '-' if negative, then
// the digits, most significant first.
// Configuration: cfg_we_i writes cfg_min_width_i; write only while idle.
//
// Operation: a value is converted bit-serially by a double-dabble shifter, one
// input bit per cycle, then leading zero digits are dropped one nibble per
// cycle. The characters of a value then follow at one character per cycle
// while the output does not stall. The converter accepts the next value once
// the emitter has taken the previous one, so conversion overlaps output; the
// sustained rate is set by the slower of conversion and character output.
// Reset clears min_width to 0 and empties both stages and the output register.
// A stall on the output holds the current character; conversion continues
// and the input stalls while the converter is busy or holds a finished number.
module signed_decimal_formatter import sdf_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [MIN_WIDTH_W-1:0]       cfg_min_width_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [CHAR_W-1:0]            text_char_o,
  output logic                         last_char_o
);

  logic [MIN_WIDTH_W-1:0] min_width_q;
  logic num_valid, num_take;
  sdf_num_t num;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_width_q <= '0;
    end else if (cfg_we_i) begin
      min_width_q <= cfg_min_width_i;
    end
  end

  sdf_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .num_valid_o (num_valid),
    .num_take_i  (num_take),
    .num_o       (num)
  );

  sdf_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .min_width_i (min_width_q),
    .num_valid_i (num_valid),
    .num_take_o  (num_take),
    .num_i       (num),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .text_char_o (text_char_o),
    .last_char_o (last_char_o)
  );

endmodule

@@ rtl/sdf_checker.sv @@
module sdf_checker import sdf_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [CHAR_W-1:0] text_char_o,
  input logic              last_char_o
);

  logic is_digit;
  assign is_digit = (text_char_o >= CHAR_ZERO) && (text_char_o <= CHAR_NINE);

  // A stalled character stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(text_char_o)
      && $stable(last_char_o))
    else $error("output changed while stalled");

  // Only blanks, minus and digits appear
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> is_digit || (text_char_o == CHAR_BLANK)
      || (text_char_o == CHAR_MINUS))
    else $error("character outside the allowed set");

  // Text always ends on a digit
  a_last_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_char_o |-> is_digit)
    else $error("last character is not a digit");

  // A sign is followed at once by a digit
  a_sign_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && (text_char_o == CHAR_MINUS)
      |=> out_valid_o && is_digit)
    else $error("sign not followed by a digit");

endmodule

bind signed_decimal_formatter sdf_checker u_sdf_checker (.*);
